### hdl/lstm_cell_forward_pointwise_unit_defines.svh
// Assertion macros shared by the pointwise unit
`ifndef LSTM_CELL_FORWARD_POINTWISE_UNIT_DEFINES_SVH
`define LSTM_CELL_FORWARD_POINTWISE_UNIT_DEFINES_SVH

// Check an expression at every edge outside reset
`define LSTMPW_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check a consequence in the cycle after its cause
`define LSTMPW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/lstmpw_pkg.sv
package lstmpw_pkg;

	localparam logic [15:0] ONE_Q15 = 16'd32768;

	// Gates and mask carried alongside the datapath
	typedef struct packed {
		logic [15:0] ig;
		logic [15:0] fg;
		logic [15:0] og;
		logic [15:0] m;
	} gates_t;

	// tanh(k/4) in Q1.15, k = 0..32
	function automatic logic [15:0] tanh_rom(input logic [5:0] k);
		logic [15:0] v;
		case (k)
			6'd0: v = 16'd0;
			6'd1: v = 16'd8025;
			6'd2: v = 16'd15143;
			6'd3: v = 16'd20813;
			6'd4: v = 16'd24956;
			6'd5: v = 16'd27797;
			6'd6: v = 16'd29660;
			6'd7: v = 16'd30847;
			6'd8: v = 16'd31589;
			6'd9: v = 16'd32048;
			6'd10: v = 16'd32329;
			6'd11: v = 16'd32501;
			6'd12: v = 16'd32606;
			6'd13: v = 16'd32670;
			6'd14: v = 16'd32708;
			6'd15: v = 16'd32732;
			6'd16: v = 16'd32746;
			6'd17: v = 16'd32755;
			6'd18: v = 16'd32760;
			6'd19: v = 16'd32763;
			6'd20: v = 16'd32765;
			6'd21: v = 16'd32766;
			6'd22: v = 16'd32767;
			6'd23: v = 16'd32767;
			default: v = ONE_Q15;
		endcase
		return v;
	endfunction

	// sigmoid from tanh(x/2): (1 + t + 1 lsb) / 2
	function automatic logic [15:0] sigmoid_q15(input logic signed [16:0] t);
		logic signed [17:0] s;
		s = 18'sd32769 + 18'(t);
		return s[16:1];
	endfunction

endpackage

### hdl/lstmpw_tanh.sv
// Table tanh with linear interpolation; half selects tanh(x/2)
module lstmpw_tanh
	import lstmpw_pkg::*;
(
	input  logic signed [15:0] x,
	input  logic               half,
	output logic signed [16:0] y
);

	logic        neg;
	logic [16:0] a;
	logic [7:0]  idx;
	logic [9:0]  ff;
	logic [15:0] t0;
	logic [15:0] t1;
	logic [15:0] d;
	logic [23:0] prod;
	logic [23:0] rnd;
	logic [16:0] mag;

	// Split magnitude into table index and fraction
	always_comb begin
		neg = x[15];
		a = neg ? 17'(-$signed({x[15], x})) : {1'b0, x};
		idx = half ? {1'b0, a[16:10]} : a[16:9];
		ff = half ? a[9:0] : {1'b0, a[8:0]};
		t0 = tanh_rom({1'b0, idx[4:0]});
		t1 = tanh_rom({1'b0, idx[4:0]} + 6'd1);
		d = t1 - t0;
		prod = 24'(d) * 24'(ff);
		rnd = half ? ((prod + 24'd512) >> 10) : ((prod + 24'd256) >> 9);
		if (idx >= 8'd32) begin
			mag = 17'(ONE_Q15);
		end else begin
			mag = 17'(t0) + rnd[16:0];
		end
		y = neg ? -$signed(mag) : $signed(mag);
	end

endmodule

### hdl/lstm_cell_forward_pointwise_unit.sv
// Throughput: one item per cycle; a stall at the output freezes the whole pipeline.
// Depth is set by the nine register stages: lookups, three multiply levels,
// the state round, the second lookup and the output multiply chain.
// Reset clears all stage valid bits; payload registers are not reset.
`include "lstm_cell_forward_pointwise_unit_defines.svh"
module lstm_cell_forward_pointwise_unit
	import lstmpw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// cell_pre, in_gate_pre, forget_pre, out_gate_pre, prev_state, step_mask
	input  logic [95:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// next_state, in_gate, forget_act, out_gate, cell_out
	output logic [79:0] m_tdata
);

	logic en;
	logic [8:1] v_q;

	logic signed [16:0] t_cell;
	logic signed [16:0] t_ig;
	logic signed [16:0] t_fg;
	logic signed [16:0] t_og;
	logic signed [16:0] t_ns;

	gates_t             g_s1, g_s2, g_s3, g_s4, g_s5, g_s6, g_s7, g_s8;
	logic signed [16:0] tc_s1;
	logic signed [15:0] prev_s1;
	logic signed [33:0] p1_s2;
	logic signed [32:0] p2_s2;
	logic signed [32:0] pm_s2;
	logic signed [37:0] sum_s3;
	logic signed [32:0] pm_s3;
	logic signed [55:0] blend_s4;
	logic signed [15:0] ns_s5, ns_s6, ns_s7, ns_s8;
	logic signed [16:0] ts_s6;
	logic signed [33:0] ot_s7;
	logic signed [50:0] otm_s8;

	logic [15:0]        m_in;
	logic signed [55:0] ns_round;
	logic signed [15:0] ns_sat;
	logic signed [50:0] co_round;
	logic signed [15:0] co_sat;

	// Advance everything unless the output holds an untaken item
	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	lstmpw_tanh u_tanh_cell (.x(s_tdata[15:0]),  .half(1'b0), .y(t_cell));
	lstmpw_tanh u_tanh_ig   (.x(s_tdata[31:16]), .half(1'b1), .y(t_ig));
	lstmpw_tanh u_tanh_fg   (.x(s_tdata[47:32]), .half(1'b1), .y(t_fg));
	lstmpw_tanh u_tanh_og   (.x(s_tdata[63:48]), .half(1'b1), .y(t_og));
	lstmpw_tanh u_tanh_ns   (.x(ns_s5),          .half(1'b0), .y(t_ns));

	// Saturate mask above one
	assign m_in = (s_tdata[95:80] > ONE_Q15) ? ONE_Q15 : s_tdata[95:80];

	// Round and saturate the blended state
	always_comb begin
		ns_round = (blend_s4 + (56'sd1 <<< 33)) >>> 34;
		if (ns_round > 56'sd32767) begin
			ns_sat = 16'sh7fff;
		end else if (ns_round < -56'sd32768) begin
			ns_sat = 16'sh8000;
		end else begin
			ns_sat = ns_round[15:0];
		end
	end

	// Round and saturate the cell output
	always_comb begin
		co_round = (otm_s8 + (51'sd1 <<< 29)) >>> 30;
		if (co_round > 51'sd32767) begin
			co_sat = 16'sd32767;
		end else if (co_round < -51'sd32767) begin
			co_sat = -16'sd32767;
		end else begin
			co_sat = co_round[15:0];
		end
	end

	// Stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			m_tvalid <= 1'b0;
		end else if (en) begin
			v_q <= {v_q[7:1], s_tvalid};
			m_tvalid <= v_q[8];
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		if (en) begin
			g_s1.ig <= sigmoid_q15(t_ig);
			g_s1.fg <= sigmoid_q15(t_fg);
			g_s1.og <= sigmoid_q15(t_og);
			g_s1.m  <= m_in;
			tc_s1   <= t_cell;
			prev_s1 <= s_tdata[79:64];

			g_s2  <= g_s1;
			p1_s2 <= 34'($signed({1'b0, g_s1.ig})) * 34'(tc_s1);
			p2_s2 <= 33'($signed({1'b0, g_s1.fg})) * 33'(prev_s1);
			pm_s2 <= 33'(prev_s1) * 33'($signed({1'b0, 17'(ONE_Q15) - 17'(g_s1.m)}));

			g_s3   <= g_s2;
			sum_s3 <= 38'(p1_s2) + (38'(p2_s2) <<< 4);
			pm_s3  <= pm_s2;

			g_s4     <= g_s3;
			blend_s4 <= 56'(sum_s3) * 56'($signed({1'b0, g_s3.m})) + (56'(pm_s3) <<< 19);

			g_s5  <= g_s4;
			ns_s5 <= ns_sat;

			g_s6  <= g_s5;
			ns_s6 <= ns_s5;
			ts_s6 <= t_ns;

			g_s7  <= g_s6;
			ns_s7 <= ns_s6;
			ot_s7 <= 34'($signed({1'b0, g_s6.og})) * 34'(ts_s6);

			g_s8   <= g_s7;
			ns_s8  <= ns_s7;
			otm_s8 <= 51'(ot_s7) * 51'($signed({1'b0, g_s7.m}));

			m_tdata <= {co_sat, g_s8.og, g_s8.fg, g_s8.ig, ns_s8};
		end
	end

	`LSTMPW_ASSERT_ALWAYS(a_gate_range, !m_tvalid || (m_tdata[31:16] <= ONE_Q15 && m_tdata[47:32] <= ONE_Q15 && m_tdata[63:48] <= ONE_Q15), "gate above one")
	`LSTMPW_ASSERT_ALWAYS(a_cell_out_sym, !m_tvalid || m_tdata[79:64] != 16'h8000, "cell output below -32767")
	`LSTMPW_ASSERT_NEXT(a_stall_freeze, m_tvalid && !m_tready, $stable(v_q) && $stable(m_tdata), "pipeline moved during stall")

endmodule
